[rtl/utf8_letter_bigram_event_extractor_assert.svh]
// assertion macros for the utf8 letter bigram event extractor
`ifndef UTF8_LETTER_BIGRAM_EVENT_EXTRACTOR_ASSERT_SVH
`define UTF8_LETTER_BIGRAM_EVENT_EXTRACTOR_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define ULBE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define ULBE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ulbe_pkg.sv]
// shared types and constants for the utf8 letter bigram event extractor
package ulbe_pkg;

    localparam int POINT_W = 21;
    localparam int BYTE_W  = 8;
    localparam int LEFT_W  = 2;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    localparam logic [POINT_W-1:0] LETTER_LOW_RST  = 21'h00AC00;
    localparam logic [POINT_W-1:0] LETTER_HIGH_RST = 21'h00D7A3;

    typedef enum logic {
        KIND_DATA  = 1'b0,
        KIND_FLUSH = 1'b1
    } t_item_kind;

    typedef enum logic [1:0] {
        EV_START = 2'd0,
        EV_PAIR  = 2'd1,
        EV_END   = 2'd2
    } t_event_kind;

    typedef enum logic {
        REG_LETTER_LOW  = 1'b0,
        REG_LETTER_HIGH = 1'b1
    } t_reg_idx;

    // result of decoding one byte against the sequence state
    typedef struct packed {
        logic               done;
        logic               valid;
        logic [POINT_W-1:0] point;
        logic [POINT_W-1:0] partial_n;
        logic [LEFT_W-1:0]  left_n;
    } t_dec_out;

endpackage

[rtl/ulbe_decode.sv]
// utf8 sequence decoder: folds one byte into the partial code point
module ulbe_decode
    import ulbe_pkg::*;
(
    input  logic               i_flush,
    input  logic [BYTE_W-1:0]  i_byte,
    input  logic [POINT_W-1:0] i_partial,
    input  logic [LEFT_W-1:0]  i_left,
    output t_dec_out           o_dec
);

    logic [POINT_W-1:0] shifted;

    assign shifted = {i_partial[POINT_W-7:0], i_byte[5:0]};

    always_comb begin
        o_dec.done      = 1'b0;
        o_dec.valid     = 1'b0;
        o_dec.point     = '0;
        o_dec.partial_n = i_partial;
        o_dec.left_n    = i_left;
        if (i_flush) begin
            o_dec.partial_n = '0;
            o_dec.left_n    = '0;
        end else if (i_left != '0) begin
            // continuation bytes are taken as they come, top bits unchecked
            o_dec.left_n = i_left - 2'd1;
            if (i_left == 2'd1) begin
                o_dec.done      = 1'b1;
                o_dec.valid     = 1'b1;
                o_dec.point     = shifted;
                o_dec.partial_n = '0;
            end else begin
                o_dec.partial_n = shifted;
            end
        end else if (!i_byte[7]) begin
            o_dec.done  = 1'b1;
            o_dec.valid = 1'b1;
            o_dec.point = {{(POINT_W-BYTE_W){1'b0}}, i_byte};
        end else if (i_byte[7:5] == 3'b110) begin
            o_dec.partial_n = {{(POINT_W-5){1'b0}}, i_byte[4:0]};
            o_dec.left_n    = 2'd1;
        end else if (i_byte[7:4] == 4'b1110) begin
            o_dec.partial_n = {{(POINT_W-4){1'b0}}, i_byte[3:0]};
            o_dec.left_n    = 2'd2;
        end else if (i_byte[7:3] == 5'b11110) begin
            o_dec.partial_n = {{(POINT_W-3){1'b0}}, i_byte[2:0]};
            o_dec.left_n    = 2'd3;
        end else begin
            // stray continuation or over-long lead: one invalid character
            o_dec.done = 1'b1;
        end
    end

endmodule

[rtl/utf8_letter_bigram_event_extractor.sv]
// Takes one UTF-8 byte (or a flush) per transfer and emits word start, letter pair and word
// end events for code points inside the configured letter range. One item can be accepted
// every cycle while o_in_stall is low. An item passes through an input register and then a
// result register on its way to o_out_valid. While an event waits in the result register
// under i_out_stall, an item held in the input register stalls the input. The rate is set
// by the single-pass decode and range compare between those registers. Items that close no
// character, other than a flush, produce no result. The letter range registers sit at byte
// addresses 0 (low) and 4 (high) and reset to 0xAC00..0xD7A3.
module utf8_letter_bigram_event_extractor
    import ulbe_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_kind,
    input  logic [BYTE_W-1:0]  i_data_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_event_kind,
    output logic [POINT_W-1:0] o_from_point,
    output logic [POINT_W-1:0] o_to_point,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

`include "utf8_letter_bigram_event_extractor_assert.svh"

    logic [POINT_W-1:0] r_letter_low;
    logic [POINT_W-1:0] r_letter_high;
    logic               cfg_write;
    t_reg_idx           reg_idx;

    logic               r_in_valid;
    logic               r_in_kind;
    logic [BYTE_W-1:0]  r_in_byte;

    logic [POINT_W-1:0] r_partial;
    logic [LEFT_W-1:0]  r_left;
    logic [POINT_W-1:0] r_prev;
    logic               r_in_word;
    logic [POINT_W-1:0] n_prev;
    logic               n_in_word;

    logic               r_out_valid;
    t_event_kind        r_event_kind;
    logic [POINT_W-1:0] r_from;
    logic [POINT_W-1:0] r_to;
    logic               n_emit;
    t_event_kind        n_event_kind;
    logic [POINT_W-1:0] n_from;
    logic [POINT_W-1:0] n_to;

    logic               out_free;
    logic               advance;
    logic               is_flush;
    logic               is_letter;
    logic               ends_char;
    t_dec_out           dec;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = t_reg_idx'(paddr[2]);

    always_comb begin
        unique case (reg_idx)
            REG_LETTER_LOW:  prdata = {{(APB_DW-POINT_W){1'b0}}, r_letter_low};
            REG_LETTER_HIGH: prdata = {{(APB_DW-POINT_W){1'b0}}, r_letter_high};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_letter_low  <= LETTER_LOW_RST;
            r_letter_high <= LETTER_HIGH_RST;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_LETTER_LOW:  r_letter_low  <= pwdata[POINT_W-1:0];
                REG_LETTER_HIGH: r_letter_high <= pwdata[POINT_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: the held item moves on whenever the result register can take a result
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_kind <= i_kind;
            r_in_byte <= i_data_byte;
        end
    end

    assign is_flush = (t_item_kind'(r_in_kind) == KIND_FLUSH);

    ulbe_decode u_decode (
        .i_flush   (is_flush),
        .i_byte    (r_in_byte),
        .i_partial (r_partial),
        .i_left    (r_left),
        .o_dec     (dec)
    );

    assign is_letter = dec.done && dec.valid &&
                       (dec.point >= r_letter_low) && (dec.point <= r_letter_high);
    // anything that is not a letter but finishes a character, or a flush, closes the word
    assign ends_char = is_flush || dec.done;

    always_comb begin
        n_emit       = 1'b0;
        n_event_kind = EV_END;
        n_from       = '0;
        n_to         = '0;
        n_prev       = r_prev;
        n_in_word    = r_in_word;
        if (is_letter) begin
            n_emit       = 1'b1;
            n_event_kind = r_in_word ? EV_PAIR : EV_START;
            n_from       = r_in_word ? r_prev : '0;
            n_to         = dec.point;
            n_prev       = dec.point;
            n_in_word    = 1'b1;
        end else if (ends_char && r_in_word) begin
            n_emit       = 1'b1;
            n_event_kind = EV_END;
            n_from       = r_prev;
            n_prev       = '0;
            n_in_word    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_left    <= '0;
            r_prev    <= '0;
            r_in_word <= 1'b0;
        end else if (advance) begin
            r_partial <= dec.partial_n;
            r_left    <= dec.left_n;
            r_prev    <= n_prev;
            r_in_word <= n_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_emit) begin
            r_event_kind <= n_event_kind;
            r_from       <= n_from;
            r_to         <= n_to;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_kind = r_event_kind;
    assign o_from_point = r_from;
    assign o_to_point   = r_to;

    `ULBE_ASSERT_IMP(a_start_no_from, r_out_valid && r_event_kind == EV_START,
        r_from == '0, "start event carries a previous letter")
    `ULBE_ASSERT_IMP(a_end_no_to, r_out_valid && r_event_kind == EV_END,
        r_to == '0, "end event carries a current letter")
    `ULBE_ASSERT_IMP(a_prev_cleared, !r_in_word,
        r_prev == '0, "previous letter kept outside a word")
    `ULBE_ASSERT_NEXT(a_flush_resets, advance && is_flush,
        r_left == '0 && r_partial == '0 && !r_in_word, "flush left decode or word state behind")

endmodule
